// ===== rtl/life_automaton_step_core_macros.svh =====
// assertion macros used by the checker file of the life automaton step core
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef LIFE_AUTOMATON_STEP_CORE_MACROS_SVH
`define LIFE_AUTOMATON_STEP_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LAS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/las_pkg.sv =====
// shared types and constants of the life automaton step core
// no dependencies; used by the core and its checker
package las_pkg;

  typedef enum logic [2:0] {
    FUNC_TOGGLE = 3'd0,
    FUNC_READ   = 3'd1,
    FUNC_CLEAR  = 3'd2,
    FUNC_SAVE   = 3'd3,
    FUNC_LOAD   = 3'd4,
    FUNC_STEP   = 3'd5
  } func_e;

  localparam int FUNC_W   = 3;
  localparam int COORD_W  = 6;
  localparam int POP_W    = 13;
  localparam int GEN_W    = 32;

  // input tdata: func, cell_x, cell_y from bit 0 up
  localparam int S_DATA_W   = 16;
  localparam int S_FUNC_LSB = 0;
  localparam int S_X_LSB    = 3;
  localparam int S_Y_LSB    = 9;

  // output tdata: cell_alive, population, generation from bit 0 up
  localparam int M_DATA_W    = 48;
  localparam int M_ALIVE_BIT = 0;
  localparam int M_POP_LSB   = 1;
  localparam int M_GEN_LSB   = 14;

  // population is counted in chunks of a row
  localparam int CHUNK_W     = 8;
  localparam int CHUNK_CNT_W = 4;

endpackage

// ===== rtl/life_automaton_step_core.sv =====
// life automaton step core: toroidal b3/s23 grid with a snapshot grid
// depends on las_pkg; both grids are row-wide synchronous memories in this module
//
// channel  dir  handshake                      tdata fields (lsb first)
// s_axis   in   s_axis_tvalid / s_axis_tready  func, cell_x, cell_y
// m_axis   out  m_axis_tvalid / m_axis_tready  cell_alive, population, generation
//
// one item at a time; save, load and step sweep the grids row by row, each through
//   the single read port of its source grid memory, which delivers one row of cells
//   per cycle
// reset: per-row valid bits clear both grids at once, no clearing pass
// a pending result sits in the output register while the next item is taken
module life_automaton_step_core #(
  parameter int GRID_SIZE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [las_pkg::S_DATA_W-1:0]  s_axis_tdata,   // func, cell_x, cell_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [las_pkg::M_DATA_W-1:0]  m_axis_tdata    // cell_alive, population, generation
);
  import las_pkg::*;

  localparam int RW       = $clog2(GRID_SIZE);
  localparam int CNT_W    = $clog2(GRID_SIZE + 5);
  localparam int NCHUNK   = (GRID_SIZE + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W    = NCHUNK * CHUNK_W;
  localparam int ROWPOP_W = $clog2(GRID_SIZE + 1);

  // step sweep milestones, counted from the first row read
  localparam logic [CNT_W-1:0] CNT_GRID     = CNT_W'(GRID_SIZE);
  localparam logic [CNT_W-1:0] CNT_FIRST_WR = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_ROW0     = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST_SH  = CNT_W'(GRID_SIZE + 1);
  localparam logic [CNT_W-1:0] CNT_LAST_WR  = CNT_W'(GRID_SIZE + 2);
  localparam logic [CNT_W-1:0] CNT_DONE     = CNT_W'(GRID_SIZE + 4);
  localparam logic [RW-1:0]    ROW_LAST     = RW'(GRID_SIZE - 1);

  typedef logic [GRID_SIZE-1:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TG_WR,
    ST_COPY,
    ST_STEP,
    ST_FIN_RD,
    ST_FIN
  } state_e;

  // coordinates wrap onto the grid; a small table over the 6-bit field
  function automatic logic [RW-1:0] mod_grid(input logic [COORD_W-1:0] v);
    logic [RW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << COORD_W); i++) begin
      if (v == COORD_W'(i)) begin
        r = RW'(i % GRID_SIZE);
      end
    end
    return r;
  endfunction

  // control and result registers
  state_e               state_q, state_d;
  func_e                func_q, func_d;
  logic [RW-1:0]        col_q, col_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [POP_W-1:0]     live_count_q, live_count_d;
  logic [GEN_W-1:0]     step_count_q, step_count_d;
  logic                 m_tvalid_q, m_tvalid_d;
  logic [M_DATA_W-1:0]  m_tdata_q, m_tdata_d;

  // grid memories, one row per entry, with per-row valid bits
  row_t                 live_mem  [GRID_SIZE];
  row_t                 saved_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] live_vld_q, saved_vld_q;
  row_t                 live_rd_q, saved_rd_q;
  logic                 live_rv_q, saved_rv_q;

  logic                 live_re, live_we, live_clr;
  logic [RW-1:0]        live_raddr, live_waddr;
  row_t                 live_wdata;
  logic                 saved_re, saved_we;
  logic [RW-1:0]        saved_raddr, saved_waddr;
  row_t                 saved_wdata;

  row_t                 live_row, saved_row, tg_row;
  logic [CNT_W-1:0]     cnt_m1, cnt_m3;

  // generation window: rows above and at the row being computed
  row_t                 win_up_q, win_mid_q, first_q;
  row_t                 dn_row, next_row;
  logic                 step_wr;

  // population pipeline: chunk counts, then row sum into the accumulator
  logic [PAD_W-1:0]       next_pad;
  logic [CHUNK_CNT_W-1:0] chunk_cnt [NCHUNK];
  logic [CHUNK_CNT_W-1:0] pc_cnt_q  [NCHUNK];
  logic                   pc_vld_q;
  logic [ROWPOP_W-1:0]    row_sum;
  logic [POP_W-1:0]       pop_acc_q;

  // unread rows are dead
  assign live_row  = live_rd_q  & {GRID_SIZE{live_rv_q}};
  assign saved_row = saved_rd_q & {GRID_SIZE{saved_rv_q}};
  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign cnt_m3    = cnt_q - CNT_W'(3);

  // toggled row for a toggle item
  always_comb begin
    tg_row         = live_row;
    tg_row[col_q]  = ~live_row[col_q];
  end

  // last row wraps to the stored copy of the old first row
  assign dn_row = (cnt_q == CNT_LAST_WR) ? first_q : live_row;

  // b3/s23 rule over the eight wrapped neighbors, one cell per column
  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
    localparam int Lf = (c == 0) ? GRID_SIZE - 1 : c - 1;
    localparam int Rt = (c == GRID_SIZE - 1) ? 0 : c + 1;
    logic [3:0] nbr;
    assign nbr = 4'(win_up_q[Lf]) + 4'(win_up_q[c]) + 4'(win_up_q[Rt])
               + 4'(win_mid_q[Lf]) + 4'(win_mid_q[Rt])
               + 4'(dn_row[Lf]) + 4'(dn_row[c]) + 4'(dn_row[Rt]);
    assign next_row[c] = (nbr == 4'd3) || (win_mid_q[c] && (nbr == 4'd2));
  end

  assign step_wr = (state_q == ST_STEP) && (cnt_q >= CNT_FIRST_WR) && (cnt_q <= CNT_LAST_WR);

  // per-chunk popcount of the row being written
  assign next_pad = PAD_W'(next_row);
  always_comb begin
    for (int i = 0; i < NCHUNK; i++) begin
      chunk_cnt[i] = '0;
      for (int j = 0; j < CHUNK_W; j++) begin
        chunk_cnt[i] = chunk_cnt[i] + CHUNK_CNT_W'(next_pad[i*CHUNK_W + j]);
      end
    end
  end

  always_comb begin
    row_sum = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      row_sum = row_sum + ROWPOP_W'(pc_cnt_q[i]);
    end
  end

  // sequencer: decode, memory port control and result
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    col_d        = col_q;
    row_d        = row_q;
    cnt_d        = cnt_q;
    live_count_d = live_count_q;
    step_count_d = step_count_q;
    m_tvalid_d   = m_tvalid_q;
    m_tdata_d    = m_tdata_q;
    live_re      = 1'b0;
    live_raddr   = row_q;
    live_we      = 1'b0;
    live_waddr   = row_q;
    live_wdata   = tg_row;
    live_clr     = 1'b0;
    saved_re     = 1'b0;
    saved_raddr  = cnt_q[RW-1:0];
    saved_we     = 1'b0;
    saved_waddr  = cnt_m1[RW-1:0];
    saved_wdata  = live_row;

    // result taken downstream frees the output register
    if (m_tvalid_q && m_axis_tready) begin
      m_tvalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = func_e'(s_axis_tdata[S_FUNC_LSB +: FUNC_W]);
          col_d   = mod_grid(s_axis_tdata[S_X_LSB +: COORD_W]);
          row_d   = mod_grid(s_axis_tdata[S_Y_LSB +: COORD_W]);
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_d = '0;
        unique case (func_q) inside
          FUNC_TOGGLE: begin
            live_re = 1'b1;
            state_d = ST_TG_WR;
          end
          FUNC_CLEAR: begin
            live_clr = 1'b1;
            state_d  = ST_FIN_RD;
          end
          FUNC_SAVE, FUNC_LOAD: begin
            state_d = ST_COPY;
          end
          FUNC_STEP: begin
            state_d = ST_STEP;
          end
          default: begin
            state_d = ST_FIN_RD;
          end
        endcase
      end
      ST_TG_WR: begin
        live_we = 1'b1;
        state_d = ST_FIN_RD;
      end
      ST_COPY: begin
        // read row cnt from the source, write row cnt-1 to the target
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q != CNT_GRID) begin
          if (func_q == FUNC_SAVE) begin
            live_re    = 1'b1;
            live_raddr = cnt_q[RW-1:0];
          end else begin
            saved_re   = 1'b1;
          end
        end
        if (cnt_q != '0) begin
          if (func_q == FUNC_SAVE) begin
            saved_we   = 1'b1;
          end else begin
            live_we    = 1'b1;
            live_waddr = cnt_m1[RW-1:0];
            live_wdata = saved_row;
          end
        end
        if (cnt_q == CNT_GRID) begin
          state_d = ST_FIN_RD;
        end
      end
      ST_STEP: begin
        // reads: last row, then rows 0 up to the last again; each write goes to row cnt-3
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q <= CNT_GRID) begin
          live_re    = 1'b1;
          live_raddr = (cnt_q == '0) ? ROW_LAST : cnt_m1[RW-1:0];
        end
        if (step_wr) begin
          live_we    = 1'b1;
          live_waddr = cnt_m3[RW-1:0];
          live_wdata = next_row;
        end
        if (cnt_q == CNT_DONE) begin
          live_count_d = pop_acc_q;
          step_count_d = step_count_q + GEN_W'(1);
          state_d      = ST_FIN_RD;
        end
      end
      ST_FIN_RD: begin
        live_re = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // read data holds until the output register is free
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = M_DATA_W'({step_count_q, live_count_q, live_row[col_q]});
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      func_q       <= FUNC_READ;
      col_q        <= '0;
      row_q        <= '0;
      cnt_q        <= '0;
      live_count_q <= '0;
      step_count_q <= '0;
      m_tvalid_q   <= 1'b0;
      m_tdata_q    <= '0;
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      col_q        <= col_d;
      row_q        <= row_d;
      cnt_q        <= cnt_d;
      live_count_q <= live_count_d;
      step_count_q <= step_count_d;
      m_tvalid_q   <= m_tvalid_d;
      m_tdata_q    <= m_tdata_d;
    end
  end

  // row valid bits: clear op drops the live grid at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_vld_q  <= '0;
      saved_vld_q <= '0;
    end else begin
      if (live_clr) begin
        live_vld_q <= '0;
      end else if (live_we) begin
        live_vld_q[live_waddr] <= 1'b1;
      end
      if (saved_we) begin
        saved_vld_q[saved_waddr] <= 1'b1;
      end
    end
  end

  // live grid memory, one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    if (live_re) begin
      live_rd_q <= live_mem[live_raddr];
      live_rv_q <= live_vld_q[live_raddr];
    end
  end

  // snapshot grid memory
  always_ff @(posedge clk_i) begin
    if (saved_we) begin
      saved_mem[saved_waddr] <= saved_wdata;
    end
    if (saved_re) begin
      saved_rd_q <= saved_mem[saved_raddr];
      saved_rv_q <= saved_vld_q[saved_raddr];
    end
  end

  // window shift as rows arrive; old row 0 kept for the wrap at the end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEP) begin
      if ((cnt_q != '0) && (cnt_q <= CNT_LAST_SH)) begin
        win_up_q  <= win_mid_q;
        win_mid_q <= live_row;
      end
      if (cnt_q == CNT_ROW0) begin
        first_q <= live_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_wr) begin
      pc_cnt_q <= chunk_cnt;
    end
  end

  // population accumulator keeps the low bits only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_vld_q  <= 1'b0;
      pop_acc_q <= '0;
    end else begin
      pc_vld_q <= step_wr;
      if ((state_q == ST_STEP) && (cnt_q == '0)) begin
        pop_acc_q <= '0;
      end else if (pc_vld_q) begin
        pop_acc_q <= pop_acc_q + POP_W'(row_sum);
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

// ===== rtl/las_checker.sv =====
// port-level checker for the life automaton step core, bound to the top level
// depends on las_pkg and life_automaton_step_core_macros.svh
`include "life_automaton_step_core_macros.svh"

module las_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [las_pkg::S_DATA_W-1:0]  s_axis_tdata,   // func, cell_x, cell_y
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [las_pkg::M_DATA_W-1:0]  m_axis_tdata    // cell_alive, population, generation
);
  import las_pkg::*;

  logic              s_xfer, m_xfer;
  logic              m_stall;
  logic [1:0]        outst_q, outst_d;
  logic [GEN_W-1:0]  last_gen_q;
  logic              have_gen_q;
  logic [GEN_W-1:0]  gen;
  logic              gen_ok;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;
  assign gen    = m_axis_tdata[M_GEN_LSB +: GEN_W];
  assign gen_ok = (gen == last_gen_q) || (gen == last_gen_q + GEN_W'(1));
  assign outst_d = outst_q + 2'(s_xfer) - 2'(m_xfer);

  // items taken in but not yet answered, and the last generation seen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q    <= '0;
      have_gen_q <= 1'b0;
      last_gen_q <= '0;
    end else begin
      outst_q <= outst_d;
      if (m_xfer) begin
        have_gen_q <= 1'b1;
        last_gen_q <= gen;
      end
    end
  end

  `LAS_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata), "stall lost data")
  `LAS_ASSERT_NEXT(a_busy_after_in, s_xfer, !s_axis_tready, "input taken while busy")
  `LAS_ASSERT_IMPL(a_no_spurious, m_axis_tvalid, outst_q != 2'd0, "result without an item")
  `LAS_ASSERT_IMPL(a_gen_advance, m_xfer && have_gen_q, gen_ok, "generation jumped")

endmodule

bind life_automaton_step_core las_checker u_las_checker (.*);
